[rtl/pwlru_pkg.sv]
`default_nettype none
package pwlru_pkg;

  localparam int PIN_ENTRIES = 64;
  localparam int LRU_ENTRIES = 64;
  localparam int KEY_BITS    = 64;
  localparam int MAX_RESULTS = 63;

  localparam int PIN_AW = $clog2(PIN_ENTRIES);
  localparam int LRU_AW = $clog2(LRU_ENTRIES);
  localparam int CNT_W  = $clog2(LRU_ENTRIES + 1);
  localparam int N_W    = $clog2(MAX_RESULTS + 1);

  localparam int CAP_W   = 40;
  localparam int TOT_W   = 41;
  localparam int SIZE_W  = 32;
  localparam int PCNT_W  = 16;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 3;
  localparam int FKEY_W  = 64;

  localparam logic [PCNT_W-1:0] COUNT_MAX = '1;

  localparam logic [FUNC_W-1:0] FN_PUT     = 2'd0;
  localparam logic [FUNC_W-1:0] FN_GUARD   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UNGUARD = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DISABLED = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_PIN  = 3'd2;
  localparam logic [STAT_W-1:0] ST_SIZE_MIS = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVER_CAP = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PSCAN_START,
    OP_PRD,
    OP_PCMP,
    OP_PIN_INC,
    OP_PIN_DEC,
    OP_PIN_NEW,
    OP_PIN_REL,
    OP_LSCAN_START,
    OP_LRD,
    OP_LCMP,
    OP_SHIFT_START,
    OP_SRD,
    OP_SWR,
    OP_APPEND,
    OP_TOUCH_END,
    OP_UNLINK_END,
    OP_LIMIT,
    OP_EV_RD,
    OP_EV_CAP,
    OP_EMIT_EV,
    OP_EMIT_DONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              st_we;
    logic [STAT_W-1:0] st_val;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              be;
    logic              cap_zero;
    logic              lim_zero;
    logic              p_done;
    logic              pfound;
    logic              pfree;
    logic              p_mis;
    logic              cnt_max;
    logic              cnt_gt1;
    logic              l_end;
    logic              lfound;
    logic              l_mis;
    logic              l_full;
    logic              s_end;
    logic              ev_more;
    logic              ev_last;
    logic              out_busy;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_PCHK,
    S_PRD,
    S_PCMP,
    S_PDEC,
    S_LCHK,
    S_LRD,
    S_LCMP,
    S_LDEC,
    S_SCHK,
    S_SRD,
    S_SWR,
    S_SEND,
    S_REL,
    S_EVCHK,
    S_EVLOOP,
    S_EV_RD,
    S_EV_CAP,
    S_EMIT_EV,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CTX_TOUCH,
    CTX_UNLINK,
    CTX_EVICT
  } ctx_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [SIZE_W-1:0]   size;
    logic [PCNT_W-1:0]   count;
  } pin_ent_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [SIZE_W-1:0]   size;
  } lru_ent_t;

endpackage
`default_nettype wire

[rtl/pwlru_ctrl.sv]
`default_nettype none
module pwlru_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire pwlru_pkg::stat_t st,
  output pwlru_pkg::cmd_t      cmd
);
  import pwlru_pkg::*;

  state_t state_r, state_nxt;
  ctx_t   ctx_r, ctx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctx_r   <= CTX_TOUCH;
    end else begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        if (st.func == FN_PUT) begin
          state_nxt = st.lim_zero ? S_FIN : S_PCHK;
        end else if (st.func == FN_GUARD || st.func == FN_UNGUARD) begin
          state_nxt = st.cap_zero ? S_FIN : S_PCHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PCHK: state_nxt = st.p_done ? S_PDEC : S_PRD;
      S_PRD:  state_nxt = S_PCMP;
      S_PCMP: state_nxt = S_PCHK;
      S_PDEC: begin
        if (st.func == FN_PUT) begin
          state_nxt = st.pfound ? S_FIN : S_LCHK;
        end else if (st.func == FN_GUARD) begin
          if (st.pfound || !st.pfree) state_nxt = S_EVCHK;
          else state_nxt = S_LCHK;
        end else begin
          if (!st.pfound || st.cnt_gt1 || st.lim_zero) state_nxt = S_EVCHK;
          else state_nxt = S_LCHK;
        end
      end
      S_LCHK: state_nxt = st.l_end ? S_LDEC : S_LRD;
      S_LRD:  state_nxt = S_LCMP;
      S_LCMP: state_nxt = S_LCHK;
      S_LDEC: begin
        if (st.func == FN_PUT) begin
          if (st.lfound && !st.l_mis) begin
            state_nxt = S_SCHK;
            ctx_nxt   = CTX_TOUCH;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (st.func == FN_GUARD) begin
          if (st.lfound) begin
            state_nxt = S_SCHK;
            ctx_nxt   = CTX_UNLINK;
          end else begin
            state_nxt = S_EVCHK;
          end
        end else begin
          if (st.lfound) begin
            if (st.l_mis) begin
              state_nxt = S_EVCHK;
            end else begin
              state_nxt = S_SCHK;
              ctx_nxt   = CTX_TOUCH;
            end
          end else begin
            state_nxt = st.l_full ? S_EVCHK : S_REL;
          end
        end
      end
      S_SCHK: state_nxt = st.s_end ? S_SEND : S_SRD;
      S_SRD:  state_nxt = S_SWR;
      S_SWR:  state_nxt = S_SCHK;
      S_SEND: begin
        case (ctx_r)
          CTX_TOUCH:  state_nxt = (st.func == FN_PUT) ? S_FIN : S_REL;
          CTX_UNLINK: state_nxt = S_EVCHK;
          CTX_EVICT:  state_nxt = S_EMIT_EV;
          default:    state_nxt = S_FIN;
        endcase
      end
      S_REL:    state_nxt = S_EVCHK;
      S_EVCHK:  state_nxt = st.be ? S_EVLOOP : S_FIN;
      S_EVLOOP: state_nxt = st.ev_more ? S_EV_RD : S_FIN;
      S_EV_RD:  state_nxt = S_EV_CAP;
      S_EV_CAP: begin
        state_nxt = S_SCHK;
        ctx_nxt   = CTX_EVICT;
      end
      S_EMIT_EV: begin
        if (!st.out_busy) state_nxt = st.ev_last ? S_IDLE : S_EV_RD;
      end
      S_FIN: begin
        if (!st.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.st_we  = 1'b0;
    cmd.st_val = ST_OK;
    in_stall   = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_DISP: begin
        if (st.func == FN_PUT) begin
          if (st.lim_zero) begin
            cmd.st_we  = 1'b1;
            cmd.st_val = ST_DISABLED;
          end else begin
            cmd.op = OP_PSCAN_START;
          end
        end else if (st.func == FN_GUARD || st.func == FN_UNGUARD) begin
          if (st.cap_zero) begin
            cmd.st_we  = 1'b1;
            cmd.st_val = ST_DISABLED;
          end else begin
            cmd.op = OP_PSCAN_START;
          end
        end
      end
      S_PRD:  cmd.op = OP_PRD;
      S_PCMP: cmd.op = OP_PCMP;
      S_PDEC: begin
        if (st.func == FN_PUT) begin
          if (!st.pfound) cmd.op = OP_LSCAN_START;
        end else if (st.func == FN_GUARD) begin
          if (st.pfound) begin
            if (st.p_mis) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_SIZE_MIS;
            end else if (st.cnt_max) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_FULL;
            end else begin
              cmd.op = OP_PIN_INC;
            end
          end else if (!st.pfree) begin
            cmd.st_we  = 1'b1;
            cmd.st_val = ST_FULL;
          end else begin
            cmd.op = OP_PIN_NEW;
          end
        end else begin
          if (!st.pfound) begin
            cmd.st_we  = 1'b1;
            cmd.st_val = ST_NOT_PIN;
          end else if (st.cnt_gt1) begin
            cmd.op = OP_PIN_DEC;
          end else if (st.lim_zero) begin
            cmd.op = OP_PIN_REL;
          end else begin
            cmd.op = OP_LSCAN_START;
          end
        end
      end
      S_LRD:  cmd.op = OP_LRD;
      S_LCMP: cmd.op = OP_LCMP;
      S_LDEC: begin
        if (st.func == FN_PUT) begin
          if (st.lfound) begin
            if (st.l_mis) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_SIZE_MIS;
            end else begin
              cmd.op = OP_SHIFT_START;
            end
          end else if (st.l_full) begin
            cmd.st_we  = 1'b1;
            cmd.st_val = ST_FULL;
          end else begin
            cmd.op = OP_APPEND;
          end
        end else if (st.func == FN_GUARD) begin
          if (st.lfound) cmd.op = OP_SHIFT_START;
        end else begin
          if (st.lfound) begin
            if (st.l_mis) begin
              cmd.op     = OP_PIN_REL;
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_SIZE_MIS;
            end else begin
              cmd.op = OP_SHIFT_START;
            end
          end else if (st.l_full) begin
            cmd.st_we  = 1'b1;
            cmd.st_val = ST_FULL;
          end else begin
            cmd.op = OP_APPEND;
          end
        end
      end
      S_SRD: cmd.op = OP_SRD;
      S_SWR: cmd.op = OP_SWR;
      S_SEND: begin
        cmd.op = (ctx_r == CTX_TOUCH) ? OP_TOUCH_END : OP_UNLINK_END;
      end
      S_REL:    cmd.op = OP_PIN_REL;
      S_EVCHK: begin
        if (st.be) cmd.op = OP_LIMIT;
      end
      S_EV_RD:  cmd.op = OP_EV_RD;
      S_EV_CAP: cmd.op = OP_EV_CAP;
      S_EMIT_EV: begin
        if (!st.out_busy) cmd.op = OP_EMIT_EV;
      end
      S_FIN: begin
        if (!st.out_busy) cmd.op = OP_EMIT_DONE;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/pwlru_dp.sv]
`default_nettype none
module pwlru_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [pwlru_pkg::CAP_W-1:0]     cfg_wr_data,
  input  wire logic [pwlru_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [pwlru_pkg::FKEY_W-1:0]    in_key,
  input  wire logic [pwlru_pkg::SIZE_W-1:0]    in_page_size,
  input  wire logic                            in_batch_end,
  input  wire pwlru_pkg::cmd_t                 cmd,
  output pwlru_pkg::stat_t                     st,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_evicted_valid,
  output logic [pwlru_pkg::FKEY_W-1:0]         out_evicted_key,
  output logic [pwlru_pkg::SIZE_W-1:0]         out_evicted_size,
  output logic [pwlru_pkg::STAT_W-1:0]         out_status,
  output logic [pwlru_pkg::CAP_W-1:0]          out_pinned_total,
  output logic [pwlru_pkg::CAP_W-1:0]          out_unpinned_total,
  output logic                                 out_last
);
  import pwlru_pkg::*;

  localparam logic [PIN_AW-1:0] PIN_LAST  = PIN_AW'(PIN_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  LRU_FULL  = CNT_W'(LRU_ENTRIES);
  localparam logic [N_W-1:0]    N_MAX     = N_W'(MAX_RESULTS);
  localparam logic [N_W-1:0]    N_MAX_M1  = N_W'(MAX_RESULTS - 1);

  logic [CAP_W-1:0]       cap_r;
  logic [TOT_W-1:0]       lim_r;
  logic [TOT_W-1:0]       pin_tot_r;
  logic [TOT_W-1:0]       lru_tot_r;
  logic [CNT_W-1:0]       lru_cnt_r;
  logic [PIN_ENTRIES-1:0] pvalid_r;

  logic [FUNC_W-1:0]      func_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [SIZE_W-1:0]      size_r;
  logic                   be_r;
  logic [STAT_W-1:0]      st_r;

  logic [PIN_AW-1:0]      pscan_r;
  logic                   pdone_r;
  logic                   pfound_r;
  logic [PIN_AW-1:0]      pidx_r;
  logic                   pfree_r;
  logic [PIN_AW-1:0]      pfree_idx_r;
  logic [SIZE_W-1:0]      psz_r;
  logic [PCNT_W-1:0]      pcnt_r;

  logic [CNT_W-1:0]       lscan_r;
  logic                   lfound_r;
  logic [LRU_AW-1:0]      lidx_r;
  logic [SIZE_W-1:0]      lsz_r;
  logic [LRU_AW-1:0]      shj_r;

  logic [KEY_BITS-1:0]    evk_r;
  logic [SIZE_W-1:0]      evs_r;
  logic [N_W-1:0]         n_r;

  logic                   out_valid_r;
  logic                   out_ev_r;
  logic [FKEY_W-1:0]      out_key_r;
  logic [SIZE_W-1:0]      out_size_r;
  logic [STAT_W-1:0]      out_st_r;
  logic [CAP_W-1:0]       out_ptot_r;
  logic [CAP_W-1:0]       out_utot_r;
  logic                   out_last_r;

  pin_ent_t pmem [PIN_ENTRIES];
  lru_ent_t lmem [LRU_ENTRIES];
  pin_ent_t prd_r;
  lru_ent_t lrd_r;

  logic              pre, pwe;
  logic [PIN_AW-1:0] praddr, pwaddr;
  pin_ent_t          pwdata;
  logic              lre, lwe;
  logic [LRU_AW-1:0] lraddr, lwaddr;
  lru_ent_t          lwdata;

  logic [SIZE_W-1:0] app_size;
  logic [CNT_W-1:0]  shj1;
  logic              p_hit;
  logic              lim_more;

  assign app_size = (func_r == FN_UNGUARD) ? psz_r : size_r;
  assign shj1     = CNT_W'(shj_r) + CNT_W'(1);
  assign p_hit    = pvalid_r[pscan_r] && (prd_r.key == key_r);
  assign lim_more = (lru_tot_r > lim_r) && (lru_cnt_r > CNT_W'(1));

  always_comb begin
    pre    = 1'b0;
    pwe    = 1'b0;
    praddr = pscan_r;
    pwaddr = pidx_r;
    pwdata = '{key: key_r, size: psz_r, count: pcnt_r};
    lre    = 1'b0;
    lwe    = 1'b0;
    lraddr = lscan_r[LRU_AW-1:0];
    lwaddr = shj_r;
    lwdata = lrd_r;
    case (cmd.op)
      OP_PRD: pre = 1'b1;
      OP_PIN_INC: begin
        pwe    = 1'b1;
        pwdata = '{key: key_r, size: psz_r, count: pcnt_r + PCNT_W'(1)};
      end
      OP_PIN_DEC: begin
        pwe    = 1'b1;
        pwdata = '{key: key_r, size: psz_r, count: pcnt_r - PCNT_W'(1)};
      end
      OP_PIN_NEW: begin
        pwe    = 1'b1;
        pwaddr = pfree_idx_r;
        pwdata = '{key: key_r, size: size_r, count: PCNT_W'(1)};
      end
      OP_LRD: lre = 1'b1;
      OP_SRD: begin
        lre    = 1'b1;
        lraddr = shj1[LRU_AW-1:0];
      end
      OP_SWR: lwe = 1'b1;
      OP_EV_RD: begin
        lre    = 1'b1;
        lraddr = '0;
      end
      OP_APPEND: begin
        lwe    = 1'b1;
        lwaddr = lru_cnt_r[LRU_AW-1:0];
        lwdata = '{key: key_r, size: app_size};
      end
      OP_TOUCH_END: begin
        lwe    = 1'b1;
        lwaddr = LRU_AW'(lru_cnt_r - CNT_W'(1));
        lwdata = '{key: key_r, size: lsz_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pre) prd_r <= pmem[praddr];
    if (pwe) pmem[pwaddr] <= pwdata;
  end

  always_ff @(posedge clk) begin
    if (lre) lrd_r <= lmem[lraddr];
    if (lwe) lmem[lwaddr] <= lwdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      lim_r       <= '0;
      pin_tot_r   <= '0;
      lru_tot_r   <= '0;
      lru_cnt_r   <= '0;
      pvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
        lim_r <= TOT_W'(cfg_wr_data);
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.st_we) st_r <= cmd.st_val;
      case (cmd.op)
        OP_LOAD: begin
          func_r <= in_func;
          key_r  <= in_key[KEY_BITS-1:0];
          size_r <= in_page_size;
          be_r   <= in_batch_end;
          st_r   <= ST_OK;
          n_r    <= '0;
        end
        OP_PSCAN_START: begin
          pscan_r  <= '0;
          pdone_r  <= 1'b0;
          pfound_r <= 1'b0;
          pfree_r  <= 1'b0;
        end
        OP_PCMP: begin
          if (p_hit) begin
            pfound_r <= 1'b1;
            pidx_r   <= pscan_r;
            psz_r    <= prd_r.size;
            pcnt_r   <= prd_r.count;
            pdone_r  <= 1'b1;
          end else begin
            if (!pvalid_r[pscan_r] && !pfree_r) begin
              pfree_r     <= 1'b1;
              pfree_idx_r <= pscan_r;
            end
            if (pscan_r == PIN_LAST) pdone_r <= 1'b1;
            else pscan_r <= pscan_r + PIN_AW'(1);
          end
        end
        OP_PIN_NEW: begin
          pvalid_r[pfree_idx_r] <= 1'b1;
          pin_tot_r <= pin_tot_r + TOT_W'(size_r);
          lscan_r   <= '0;
          lfound_r  <= 1'b0;
        end
        OP_PIN_REL: begin
          pvalid_r[pidx_r] <= 1'b0;
          pin_tot_r <= pin_tot_r - TOT_W'(psz_r);
        end
        OP_LSCAN_START: begin
          lscan_r  <= '0;
          lfound_r <= 1'b0;
        end
        OP_LCMP: begin
          if (lrd_r.key == key_r) begin
            lfound_r <= 1'b1;
            lidx_r   <= lscan_r[LRU_AW-1:0];
            lsz_r    <= lrd_r.size;
          end else begin
            lscan_r <= lscan_r + CNT_W'(1);
          end
        end
        OP_SHIFT_START: shj_r <= lidx_r;
        OP_SWR:         shj_r <= shj_r + LRU_AW'(1);
        OP_APPEND: begin
          lru_cnt_r <= lru_cnt_r + CNT_W'(1);
          lru_tot_r <= lru_tot_r + TOT_W'(app_size);
        end
        OP_UNLINK_END: begin
          lru_cnt_r <= lru_cnt_r - CNT_W'(1);
          lru_tot_r <= lru_tot_r - TOT_W'(lsz_r);
        end
        OP_LIMIT: begin
          if (pin_tot_r > TOT_W'(cap_r)) begin
            lim_r <= '0;
            st_r  <= ST_OVER_CAP;
          end else begin
            lim_r <= TOT_W'(cap_r) - pin_tot_r;
          end
        end
        OP_EV_CAP: begin
          evk_r <= lrd_r.key;
          evs_r <= lrd_r.size;
          lsz_r <= lrd_r.size;
          lidx_r <= '0;
          shj_r <= '0;
        end
        OP_EMIT_EV: begin
          out_valid_r <= 1'b1;
          out_ev_r    <= 1'b1;
          out_key_r   <= FKEY_W'(evk_r);
          out_size_r  <= evs_r;
          out_st_r    <= st_r;
          out_ptot_r  <= pin_tot_r[CAP_W-1:0];
          out_utot_r  <= lru_tot_r[CAP_W-1:0];
          out_last_r  <= !(lim_more && (n_r < N_MAX_M1));
          n_r         <= n_r + N_W'(1);
        end
        OP_EMIT_DONE: begin
          out_valid_r <= 1'b1;
          out_ev_r    <= 1'b0;
          out_key_r   <= '0;
          out_size_r  <= '0;
          out_st_r    <= st_r;
          out_ptot_r  <= pin_tot_r[CAP_W-1:0];
          out_utot_r  <= lru_tot_r[CAP_W-1:0];
          out_last_r  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st.func     = func_r;
    st.be       = be_r;
    st.cap_zero = (cap_r == '0);
    st.lim_zero = (lim_r == '0);
    st.p_done   = pdone_r;
    st.pfound   = pfound_r;
    st.pfree    = pfree_r;
    st.p_mis    = (psz_r != size_r);
    st.cnt_max  = (pcnt_r == COUNT_MAX);
    st.cnt_gt1  = (pcnt_r > PCNT_W'(1));
    st.l_end    = lfound_r || (lscan_r >= lru_cnt_r);
    st.lfound   = lfound_r;
    st.l_mis    = (lsz_r != app_size);
    st.l_full   = (lru_cnt_r >= LRU_FULL);
    st.s_end    = (shj1 >= lru_cnt_r);
    st.ev_more  = lim_more && (n_r < N_MAX);
    st.ev_last  = !(lim_more && (n_r < N_MAX_M1));
    st.out_busy = out_valid_r;
  end

  assign out_valid          = out_valid_r;
  assign out_evicted_valid  = out_ev_r;
  assign out_evicted_key    = out_key_r;
  assign out_evicted_size   = out_size_r;
  assign out_status         = out_st_r;
  assign out_pinned_total   = out_ptot_r;
  assign out_unpinned_total = out_utot_r;
  assign out_last           = out_last_r;

endmodule
`default_nettype wire

[rtl/pinned_size_weighted_lru_unit.sv]
// Pinned, size-weighted LRU manager for a byte-budgeted page cache.
// Input channel (in_valid/in_stall) carries one word per operation: put,
// guard (pin) or unguard (release) of a 64-bit key with its page size, and
// a batch_end flag that starts LRU eviction after a guard or unguard. Result
// channel (out_valid/out_stall) returns one word per evicted key, or a single
// word when nothing is evicted; out_last marks the final word of an item.
// cfg_wr_en/cfg_wr_data load capacity_bytes and the LRU limit; write only
// while idle.
// Items are handled one at a time. The pin table is scanned entry by entry
// (check, read, compare) until a hit or its last entry, the LRU list likewise
// over its live entries, and unlinking or touching an LRU entry compacts the
// list by moving each younger entry down one slot (read, then write). Each
// eviction costs a read of the oldest entry plus a full list compaction.
// in_stall is high from acceptance until the last result word is loaded.
// Reset (synchronous, rst_n low) empties both tables and zeroes the totals
// and capacity. A stalled result holds its word; processing of the current
// item pauses only at the points where it must hand over a word.
`default_nettype none
module pinned_size_weighted_lru_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pwlru_pkg::CAP_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pwlru_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [pwlru_pkg::FKEY_W-1:0]  in_key,
  input  wire logic [pwlru_pkg::SIZE_W-1:0]  in_page_size,
  input  wire logic                          in_batch_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_evicted_valid,
  output logic [pwlru_pkg::FKEY_W-1:0]       out_evicted_key,
  output logic [pwlru_pkg::SIZE_W-1:0]       out_evicted_size,
  output logic [pwlru_pkg::STAT_W-1:0]       out_status,
  output logic [pwlru_pkg::CAP_W-1:0]        out_pinned_total,
  output logic [pwlru_pkg::CAP_W-1:0]        out_unpinned_total,
  output logic                               out_last
);
  import pwlru_pkg::*;

  cmd_t  cmd;
  stat_t st;

  pwlru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pwlru_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_func            (in_func),
    .in_key             (in_key),
    .in_page_size       (in_page_size),
    .in_batch_end       (in_batch_end),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_key    (out_evicted_key),
    .out_evicted_size   (out_evicted_size),
    .out_status         (out_status),
    .out_pinned_total   (out_pinned_total),
    .out_unpinned_total (out_unpinned_total),
    .out_last           (out_last)
  );

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
module testbench;
  import pwlru_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam logic [CAP_W-1:0] CAP_MAX = '1;
  localparam int IDLE_LIMIT = 40000;
  localparam int POOL = 24;
  localparam int EXP_DEPTH = 4096;

  typedef struct packed {
    logic              ev_valid;
    logic [63:0]       ev_key;
    logic [31:0]       ev_size;
    logic [STAT_W-1:0] status;
    logic [CAP_W-1:0]  pinned;
    logic [CAP_W-1:0]  unpinned;
    logic              last;
  } evict_word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [63:0] in_key = '0;
  logic [31:0] in_page_size = '0;
  logic in_batch_end = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_evicted_valid;
  logic [63:0] out_evicted_key;
  logic [31:0] out_evicted_size;
  logic [STAT_W-1:0] out_status;
  logic [CAP_W-1:0] out_pinned_total;
  logic [CAP_W-1:0] out_unpinned_total;
  logic out_last;

  pinned_size_weighted_lru_unit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func), .in_key(in_key),
    .in_page_size(in_page_size), .in_batch_end(in_batch_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_evicted_valid(out_evicted_valid), .out_evicted_key(out_evicted_key),
    .out_evicted_size(out_evicted_size), .out_status(out_status),
    .out_pinned_total(out_pinned_total), .out_unpinned_total(out_unpinned_total),
    .out_last(out_last)
  );

  initial forever #5 clk = ~clk;

  // shadow cache state
  bit          pin_v [64];
  logic [63:0] pin_k [64];
  logic [31:0] pin_s [64];
  int unsigned pin_c [64];
  bit          lru_v [64];
  logic [63:0] lru_k [64];
  logic [31:0] lru_s [64];
  int unsigned lru_a [64];
  int unsigned lru_cnt = 0;
  logic [TOT_W-1:0] pinned_b = '0;
  logic [TOT_W-1:0] lru_b = '0;
  logic [TOT_W-1:0] lim = '0;
  logic [CAP_W-1:0] cap = '0;

  evict_word_t exp_buf [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  bit steady = 0;
  int idle_cyc = 0;
  logic [63:0] pool_k [POOL];
  logic [31:0] pool_s [POOL];
  logic [63:0] held_k [64];
  int held_n = 0;

  function automatic int pin_find(logic [63:0] k);
    for (int i = 0; i < 64; i++) if (pin_v[i] && pin_k[i] == k) return i;
    return -1;
  endfunction

  function automatic int lru_find(logic [63:0] k);
    for (int i = 0; i < 64; i++) if (lru_v[i] && lru_k[i] == k) return i;
    return -1;
  endfunction

  function automatic void close_gap(int unsigned a);
    for (int j = 0; j < 64; j++) if (lru_v[j] && lru_a[j] > a) lru_a[j]--;
  endfunction

  function automatic void lru_unlink(int i);
    lru_v[i] = 0;
    close_gap(lru_a[i]);
    lru_cnt--;
    lru_b -= lru_s[i];
  endfunction

  function automatic logic [STAT_W-1:0] lru_insert(logic [63:0] k, logic [31:0] s);
    int i;
    i = lru_find(k);
    if (i >= 0) begin
      if (lru_s[i] != s) return ST_SIZE_MIS;
      lru_v[i] = 0;
      close_gap(lru_a[i]);
      lru_v[i] = 1;
      lru_a[i] = lru_cnt - 1;
      return ST_OK;
    end
    for (i = 0; i < 64; i++) begin
      if (!lru_v[i]) begin
        lru_v[i] = 1;
        lru_k[i] = k;
        lru_s[i] = s;
        lru_a[i] = lru_cnt;
        lru_cnt++;
        lru_b += s;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic void push_word(logic v, logic [63:0] k, logic [31:0] s,
                                    logic [STAT_W-1:0] st);
    evict_word_t w;
    w = '{v, k, s, st, pinned_b[CAP_W-1:0], lru_b[CAP_W-1:0], 1'b0};
    exp_buf[exp_wr % EXP_DEPTH] = w;
    exp_wr++;
  endfunction

  function automatic void predict(logic [FUNC_W-1:0] f, logic [63:0] k,
                                  logic [31:0] s, logic b);
    logic [STAT_W-1:0] st;
    bit run_ev;
    int n, p, l;
    logic [63:0] ek;
    logic [31:0] es;
    st = ST_OK;
    run_ev = 0;
    n = 0;
    if (f == FN_PUT) begin
      if (lim == 0) st = ST_DISABLED;
      else if (pin_find(k) < 0) st = lru_insert(k, s);
    end else if (f == FN_GUARD || f == FN_UNGUARD) begin
      if (cap == 0) begin
        st = ST_DISABLED;
      end else begin
        p = pin_find(k);
        if (f == FN_GUARD) begin
          if (p >= 0) begin
            if (pin_s[p] != s) st = ST_SIZE_MIS;
            else if (pin_c[p] >= 65535) st = ST_FULL;
            else pin_c[p]++;
          end else begin
            p = 0;
            while (p < 64 && pin_v[p]) p++;
            if (p >= 64) begin
              st = ST_FULL;
            end else begin
              pin_v[p] = 1;
              pin_k[p] = k;
              pin_s[p] = s;
              pin_c[p] = 1;
              pinned_b += s;
              l = lru_find(k);
              if (l >= 0) lru_unlink(l);
            end
          end
        end else if (p < 0) begin
          st = ST_NOT_PIN;
        end else if (pin_c[p] > 1) begin
          pin_c[p]--;
        end else begin
          if (lim != 0) begin
            l = lru_find(k);
            if (l < 0 && lru_cnt >= 64) st = ST_FULL;
            else st = lru_insert(k, pin_s[p]);
          end
          if (st != ST_FULL) begin
            pin_v[p] = 0;
            pinned_b -= pin_s[p];
          end
        end
        run_ev = b;
      end
    end
    if (run_ev) begin
      if (pinned_b > cap) begin
        lim = '0;
        st = ST_OVER_CAP;
      end else begin
        lim = cap - pinned_b;
      end
      while (lru_b > lim && lru_cnt > 1 && n < MAX_RESULTS) begin
        l = -1;
        for (int i = 0; i < 64; i++) if (lru_v[i] && lru_a[i] == 0) l = i;
        if (l < 0) break;
        ek = lru_k[l];
        es = lru_s[l];
        lru_unlink(l);
        push_word(1'b1, ek, es, st);
        n++;
      end
    end
    if (n == 0) push_word(1'b0, '0, '0, st);
    exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
  endfunction

  task automatic send_word(logic [FUNC_W-1:0] f, logic [63:0] k, logic [31:0] s, logic b);
    if (!steady) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    in_func <= f;
    in_key <= k;
    in_page_size <= s;
    in_batch_end <= b;
    do @(posedge clk); while (in_stall);
    predict(f, k, s, b);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 0;
    cap = c;
    lim = {1'b0, c};
  endtask

  // result checker
  always @(posedge clk) begin
    evict_word_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_evicted_valid, out_evicted_key, out_evicted_size, out_status,
              out_pinned_total, out_unpinned_total, out_last};
      if (exp_wr == exp_rd) begin
        errors++;
        $display("%0t unexpected word: got %p", $time, got);
      end else begin
        want = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got !== want) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 34);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_disabled();
    send_word(FN_PUT, 64'h1, 32'd10, 1'b0);
    send_word(FN_GUARD, 64'h2, 32'hFFFF_FFFF, 1'b1);
    send_word(FN_UNGUARD, 64'h2, 32'd0, 1'b1);
    send_word(FN_UNUSED, '1, '1, 1'b1);
  endtask

  task automatic test_put_guard();
    set_capacity(CAP_MAX);
    send_word(FN_PUT, 64'hA, 32'd0, 1'b0);
    send_word(FN_PUT, 64'hA, 32'd5, 1'b0);
    send_word(FN_PUT, 64'hB, 32'hFFFF_FFFF, 1'b0);
    send_word(FN_PUT, '1, 32'd77, 1'b1);
    send_word(FN_PUT, 64'hA, 32'd0, 1'b0);
    send_word(FN_GUARD, 64'hA, 32'd0, 1'b0);
    send_word(FN_PUT, 64'hA, 32'd0, 1'b0);
    send_word(FN_GUARD, 64'hA, 32'd7, 1'b0);
    send_word(FN_GUARD, 64'hA, 32'd0, 1'b1);
    send_word(FN_UNGUARD, 64'hA, 32'd0, 1'b0);
    send_word(FN_UNGUARD, 64'hA, 32'd0, 1'b1);
    send_word(FN_UNGUARD, 64'hDEAD, 32'd0, 1'b1);
    send_word(FN_UNUSED, 64'h0, 32'd0, 1'b0);
  endtask

  task automatic test_full_tables();
    logic [63:0] k;
    set_capacity(CAP_MAX);
    while (lru_cnt < 64) send_word(FN_PUT, {$urandom, $urandom}, $urandom_range(4096), 1'b0);
    send_word(FN_PUT, 64'h5151, 32'd9, 1'b0);
    held_n = 0;
    while (held_n < 64) begin
      k = {$urandom, $urandom};
      held_k[held_n] = k;
      held_n++;
      send_word(FN_GUARD, k, $urandom, 1'b0);
    end
    send_word(FN_GUARD, 64'h7777, 32'd1, 1'b0);
    send_word(FN_UNGUARD, held_k[0], 32'd0, 1'b0);
  endtask

  task automatic test_over_capacity();
    set_capacity(40'd100);
    send_word(FN_GUARD, held_k[1], pin_s[pin_find(held_k[1])], 1'b1);
    for (int i = 0; i < held_n; i++) send_word(FN_UNGUARD, held_k[i], 32'd0, i == held_n - 1);
    set_capacity(40'd50000);
    send_word(FN_GUARD, 64'hC0FFEE, 32'd20000, 1'b1);
    send_word(FN_UNGUARD, 64'hC0FFEE, 32'd0, 1'b1);
  endtask

  task automatic test_random(int items, logic [CAP_W-1:0] c, int smax);
    int r, i;
    logic [31:0] s;
    set_capacity(c);
    for (i = 0; i < POOL; i++) begin
      pool_k[i] = {$urandom, $urandom};
      pool_s[i] = (i == 0) ? 32'd0 : $urandom_range(smax, 1);
    end
    for (i = 0; i < items; i++) begin
      steady = (i < 40) && (c == CAP_MAX);
      r = $urandom_range(99);
      s = pool_s[$urandom_range(POOL-1)];
      if (r < 45) send_word(FN_GUARD, pool_k[$urandom_range(POOL-1)], s, 1'b0);
      else if (r < 80) send_word(FN_UNGUARD, pool_k[$urandom_range(POOL-1)], s, 1'b0);
      else if (r < 95) send_word(FN_PUT, pool_k[$urandom_range(POOL-1)], s, 1'b0);
      else send_word(FUNC_W'($urandom_range(3)), {$urandom, $urandom}, $urandom,
                     1'($urandom_range(1)));
      if (r >= 95) continue;
      r = $urandom_range(POOL-1);
      if ($urandom_range(99) < 30) begin
        send_word($urandom_range(1) ? FN_GUARD : FN_UNGUARD, pool_k[r], pool_s[r], 1'b1);
        i++;
      end
    end
    steady = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_disabled();
    test_put_guard();
    test_full_tables();
    test_over_capacity();
    test_random(20, 40'd200000, 65536);
    test_random(20, CAP_MAX, 32'hFFFF_FFFF);
    test_random(20, 40'd3000, 800);
    set_capacity(40'd0);
    send_word(FN_GUARD, pool_k[1], pool_s[1], 1'b1);
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[pinned_size_weighted_lru_unit.f]
rtl/pwlru_pkg.sv
rtl/pwlru_ctrl.sv
rtl/pwlru_dp.sv
rtl/pinned_size_weighted_lru_unit.sv
dv/testbench.sv
